[design/shbg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shbg_pkg - shared types and constants of the spatial hash bucket generator
// Primes of the hash, register map, queue entry, front state machine and the
// restoring divide step used by the quantizers and the reciprocal unit.
// ----------------------------------------------------------------------------
package shbg_pkg;

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    localparam int DEF_MAX_BUCKETS = 65536;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int ADDR_W = 3;
    localparam logic [30:0] CELL_SIZE_RST  = 31'd65536;
    localparam logic [16:0] TABLE_SIZE_RST = 17'd4096;

    // two quotient bits per cycle over a 32-bit dividend
    localparam int DIV_CYCLES = 16;

    typedef enum logic {
        REG_CELL_SIZE  = 1'b0,
        REG_TABLE_SIZE = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [31:0] iz;
    } q_entry_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } div_state_t;

    // width of the effective table size for a given bucket limit
    function automatic int tbl_w(input int max_b);
        if (max_b >= 131071)
        begin
            return 17;
        end
        return $clog2(max_b + 1);
    endfunction

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_state_t div_step(input div_state_t cur, input logic [31:0] d);
        logic [32:0] rs;
        logic [32:0] diff;
        div_state_t  nx;
        rs     = {cur.rem, cur.quo[31]};
        diff   = rs - {1'b0, d};
        nx.quo = {cur.quo[30:0], ~diff[32]};
        nx.rem = diff[32] ? rs[31:0] : diff[31:0];
        return nx;
    endfunction

endpackage
`default_nettype wire

[design/shbg_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shbg_front - item intake and cell quantization
// Buffers one item, divides the three coordinates by the cell size with
// radix-4 restoring dividers in parallel and pushes the cell indices.
// ----------------------------------------------------------------------------
module shbg_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               opcode,
    input  wire logic [31:0]        pos_x,
    input  wire logic [31:0]        pos_y,
    input  wire logic [31:0]        pos_z,
    input  wire logic [30:0]        cell_size,
    input  wire logic               fifo_full,
    output logic                    push,
    output shbg_pkg::q_entry_t      push_entry
);

    localparam int CNT_W = $clog2(shbg_pkg::DIV_CYCLES);

    shbg_pkg::front_state_t state_reg, state_next;

    logic              buf_full_reg;
    logic              buf_op_reg;
    logic [31:0]       buf_pos_reg [3];

    logic [CNT_W-1:0]  cnt_reg;
    shbg_pkg::op_t     op_reg;
    logic              neg_reg [3];
    shbg_pkg::div_state_t dv_reg [3];
    shbg_pkg::div_state_t dv_next [3];
    shbg_pkg::div_state_t dv_load [3];
    logic              neg_load [3];
    logic [31:0]       quant [3];

    logic              accept;
    logic              load;
    logic              step;
    logic [31:0]       divisor;

    assign accept    = req_valid && !buf_full_reg;
    assign req_stall = buf_full_reg;
    assign divisor   = {1'b0, cell_size};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shbg_pkg::FR_IDLE:
            begin
                if (buf_full_reg)
                begin
                    state_next = shbg_pkg::FR_DIV;
                end
            end
            shbg_pkg::FR_DIV:
            begin
                if (cnt_reg == CNT_W'(shbg_pkg::DIV_CYCLES - 1))
                begin
                    state_next = shbg_pkg::FR_PUSH;
                end
            end
            shbg_pkg::FR_PUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = buf_full_reg ? shbg_pkg::FR_DIV : shbg_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = shbg_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load = 1'b0;
        step = 1'b0;
        push = 1'b0;
        unique case (state_reg)
            shbg_pkg::FR_IDLE:
            begin
                load = buf_full_reg;
            end
            shbg_pkg::FR_DIV:
            begin
                step = 1'b1;
            end
            shbg_pkg::FR_PUSH:
            begin
                push = !fifo_full;
                load = !fifo_full && buf_full_reg;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            neg_load[l]    = buf_pos_reg[l][31];
            dv_load[l].rem = 32'd0;
            dv_load[l].quo = buf_pos_reg[l][31] ? (32'd0 - buf_pos_reg[l]) : buf_pos_reg[l];
            dv_next[l]     = shbg_pkg::div_step(shbg_pkg::div_step(dv_reg[l], divisor), divisor);
            quant[l]       = neg_reg[l] ? (32'd0 - dv_reg[l].quo) : dv_reg[l].quo;
        end
    end

    assign push_entry.opcode = op_reg;
    assign push_entry.ix     = quant[0];
    assign push_entry.iy     = quant[1];
    assign push_entry.iz     = quant[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= shbg_pkg::FR_IDLE;
            buf_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                buf_full_reg <= 1'b1;
            end
            else if (load)
            begin
                buf_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_op_reg     <= opcode;
            buf_pos_reg[0] <= pos_x;
            buf_pos_reg[1] <= pos_y;
            buf_pos_reg[2] <= pos_z;
        end
        if (load)
        begin
            cnt_reg <= '0;
            op_reg  <= shbg_pkg::op_t'(buf_op_reg);
            for (int l = 0; l < 3; l++)
            begin
                neg_reg[l] <= neg_load[l];
                dv_reg[l]  <= dv_load[l];
            end
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int l = 0; l < 3; l++)
            begin
                dv_reg[l] <= dv_next[l];
            end
        end
    end

endmodule
`default_nettype wire

[design/shbg_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shbg_fifo - short queue between front and back
// Holds quantized cells so that intake and hashing stall independently.
// ----------------------------------------------------------------------------
module shbg_fifo
#(
    parameter int DEPTH = shbg_pkg::DEF_QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire shbg_pkg::q_entry_t din,
    input  wire logic               pop,
    output shbg_pkg::q_entry_t      dout,
    output logic                    full,
    output logic                    empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    shbg_pkg::q_entry_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

[design/shbg_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shbg_back - neighbour sequencer and hash pipeline
// Walks the own cell or the 27 neighbour cells, hashes each cell and reduces
// it modulo the table size through a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module shbg_back
#(
    parameter int MAX_BUCKETS = shbg_pkg::DEF_MAX_BUCKETS
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire shbg_pkg::q_entry_t                       entry,
    input  wire logic                                     fifo_empty,
    output logic                                          pop,
    input  wire logic [shbg_pkg::tbl_w(MAX_BUCKETS)-1:0]  table_eff,
    input  wire logic                                     tbl_wr,
    output logic                                          rsp_valid,
    input  wire logic                                     rsp_stall,
    output logic [15:0]                                   bucket,
    output logic                                          last
);

    localparam int TW    = shbg_pkg::tbl_w(MAX_BUCKETS);
    localparam int RW    = TW + 1;
    localparam int CNT_W = $clog2(shbg_pkg::DIV_CYCLES);

    // reciprocal floor((2^32-1)/T), recomputed after reset and table writes
    logic                 rc_start_reg;
    logic                 rc_busy_reg;
    logic [CNT_W-1:0]     rc_cnt_reg;
    shbg_pkg::div_state_t rc_reg;
    logic                 rc_ready;

    shbg_pkg::q_entry_t   ent_reg;
    logic                 act_reg;
    logic                 ins_reg;
    logic [1:0]           a_reg, b_reg, c_reg;

    logic                 advance;
    logic                 issue;
    logic                 done;

    logic                 s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s0_last_reg, s1_last_reg, s2_last_reg, s3_last_reg;
    logic [31:0]          s0_i_reg, s0_j_reg, s0_k_reg;
    logic [31:0]          s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [31:0]          s2_h_reg, s2_q_reg;
    logic [RW-1:0]        s3_r_reg;
    logic                 o_valid_reg;
    logic                 o_last_reg;
    logic [15:0]          o_bucket_reg;

    logic [31:0]          hash;
    logic [63:0]          hm;
    logic [2*RW-1:0]      qt;
    logic [RW-1:0]        r_fix;

    assign rc_ready = !rc_start_reg && !rc_busy_reg;
    assign advance  = !(o_valid_reg && rsp_stall);
    assign issue    = act_reg && advance;
    assign done     = issue && (ins_reg || (a_reg == 2'd2 && b_reg == 2'd2 && c_reg == 2'd2));
    assign pop      = !fifo_empty && rc_ready && (!act_reg || done);

    assign hash  = s1_px_reg ^ s1_py_reg ^ s1_pz_reg;
    assign hm    = 64'(hash) * 64'(rc_reg.quo);
    assign qt    = s2_q_reg[RW-1:0] * RW'(table_eff);
    assign r_fix = (s3_r_reg >= RW'(table_eff)) ? s3_r_reg - RW'(table_eff) : s3_r_reg;

    assign rsp_valid = o_valid_reg;
    assign bucket    = o_bucket_reg;
    assign last      = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_start_reg <= 1'b1;
            rc_busy_reg  <= 1'b0;
        end
        else
        begin
            if (tbl_wr)
            begin
                rc_start_reg <= 1'b1;
            end
            else if (rc_start_reg)
            begin
                rc_start_reg <= 1'b0;
                rc_busy_reg  <= 1'b1;
            end
            else if (rc_busy_reg && rc_cnt_reg == CNT_W'(shbg_pkg::DIV_CYCLES - 1))
            begin
                rc_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rc_start_reg)
        begin
            rc_cnt_reg <= '0;
            rc_reg.rem <= 32'd0;
            rc_reg.quo <= 32'hFFFF_FFFF;
        end
        else if (rc_busy_reg)
        begin
            rc_cnt_reg <= rc_cnt_reg + CNT_W'(1);
            rc_reg     <= shbg_pkg::div_step(shbg_pkg::div_step(rc_reg, 32'(table_eff)),
                                             32'(table_eff));
        end
    end

    // sequencer: an insert sits at offset (1,1,1), a query counts from (0,0,0)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (pop)
        begin
            act_reg <= 1'b1;
        end
        else if (done)
        begin
            act_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= entry;
            ins_reg <= (entry.opcode == shbg_pkg::OP_INSERT);
            a_reg   <= (entry.opcode == shbg_pkg::OP_INSERT) ? 2'd1 : 2'd0;
            b_reg   <= (entry.opcode == shbg_pkg::OP_INSERT) ? 2'd1 : 2'd0;
            c_reg   <= (entry.opcode == shbg_pkg::OP_INSERT) ? 2'd1 : 2'd0;
        end
        else if (issue)
        begin
            if (c_reg == 2'd2)
            begin
                c_reg <= 2'd0;
                if (b_reg == 2'd2)
                begin
                    b_reg <= 2'd0;
                    a_reg <= a_reg + 2'd1;
                end
                else
                begin
                    b_reg <= b_reg + 2'd1;
                end
            end
            else
            begin
                c_reg <= c_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            o_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_last_reg  <= done;
            s0_i_reg     <= ent_reg.ix + 32'(a_reg) - 32'd1;
            s0_j_reg     <= ent_reg.iy + 32'(b_reg) - 32'd1;
            s0_k_reg     <= ent_reg.iz + 32'(c_reg) - 32'd1;

            s1_last_reg  <= s0_last_reg;
            s1_px_reg    <= s0_i_reg * shbg_pkg::PRIME_X;
            s1_py_reg    <= s0_j_reg * shbg_pkg::PRIME_Y;
            s1_pz_reg    <= s0_k_reg * shbg_pkg::PRIME_Z;

            s2_last_reg  <= s1_last_reg;
            s2_h_reg     <= hash;
            s2_q_reg     <= hm[63:32];

            // quotient estimate is low by at most one, so the remainder is below 2T
            s3_last_reg  <= s2_last_reg;
            s3_r_reg     <= s2_h_reg[RW-1:0] - qt[RW-1:0];

            o_last_reg   <= s3_last_reg;
            o_bucket_reg <= 16'(r_fix);
        end
    end

endmodule
`default_nettype wire

[design/spatial_hash_bucket_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spatial_hash_bucket_generator - spatial hash bucket generator, top level
// Usage: an item (opcode, pos_x, pos_y, pos_z in signed Q16.16) enters on the
// req channel; buckets leave on the rsp channel, last high on the final one.
// An insert gives one bucket (own cell), a query 27 (x outermost, z innermost).
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The user writes cell_size (address 0) and table_size (address 4)
// over APB only while no item is in flight; the block does not enforce it.
// Throughput: a query gives one bucket per cycle on rsp while rsp_stall is
// low. Inserts are paced by the three radix-4 dividers that quantize the
// coordinates before a push into the queue; the next item can wait in the
// input buffer meanwhile. From accept to the first bucket: input buffer,
// divide steps, queue write and pop, and a five-stage hash pipeline.
// Reset: registers return to cell_size 1.0 and table_size 4096; the modulus
// reciprocal is then recomputed, likewise after each table_size write, and
// items wait in the queue meanwhile.
// A stall on rsp holds the bucket and freezes the hash pipeline; the front
// keeps dividing and fills the queue before req_stall rises.
// ----------------------------------------------------------------------------
module spatial_hash_bucket_generator
#(
    parameter int MAX_BUCKETS = shbg_pkg::DEF_MAX_BUCKETS,
    parameter int QUEUE_DEPTH = shbg_pkg::DEF_QUEUE_DEPTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic                        opcode,
    input  wire logic signed [31:0]          pos_x,
    input  wire logic signed [31:0]          pos_y,
    input  wire logic signed [31:0]          pos_z,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic [15:0]                      bucket,
    output logic                             last,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [shbg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int TW = shbg_pkg::tbl_w(MAX_BUCKETS);

    logic [30:0]        cell_size_reg;
    logic [16:0]        table_size_reg;
    logic [30:0]        cell_eff;
    logic [16:0]        table_nz;
    logic [TW-1:0]      table_eff;
    logic               wr;
    logic               tbl_wr;
    shbg_pkg::reg_idx_t idx;

    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    shbg_pkg::q_entry_t push_entry;
    shbg_pkg::q_entry_t pop_entry;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = shbg_pkg::reg_idx_t'(paddr[2]);
    assign tbl_wr = wr && (idx == shbg_pkg::REG_TABLE_SIZE);

    always_comb
    begin
        unique case (idx)
            shbg_pkg::REG_CELL_SIZE:  prdata = {1'b0, cell_size_reg};
            shbg_pkg::REG_TABLE_SIZE: prdata = {15'd0, table_size_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg  <= shbg_pkg::CELL_SIZE_RST;
            table_size_reg <= shbg_pkg::TABLE_SIZE_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                shbg_pkg::REG_CELL_SIZE:  cell_size_reg  <= pwdata[30:0];
                shbg_pkg::REG_TABLE_SIZE: table_size_reg <= pwdata[16:0];
                default:                  cell_size_reg  <= cell_size_reg;
            endcase
        end
    end

    // zero sizes count as one; the table saturates at the bucket limit
    assign cell_eff  = (cell_size_reg == 31'd0) ? 31'd1 : cell_size_reg;
    assign table_nz  = (table_size_reg == 17'd0) ? 17'd1 : table_size_reg;
    assign table_eff = (32'(table_nz) > 32'(MAX_BUCKETS)) ? TW'(MAX_BUCKETS) : TW'(table_nz);

    shbg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .cell_size  (cell_eff),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    shbg_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_entry),
        .pop   (pop),
        .dout  (pop_entry),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    shbg_back
    #(
        .MAX_BUCKETS (MAX_BUCKETS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (pop_entry),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .table_eff  (table_eff),
        .tbl_wr     (tbl_wr),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .bucket     (bucket),
        .last       (last)
    );

endmodule
`default_nettype wire

[design/shbg_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shbg_checker - port-level checks of the spatial hash bucket generator
// Tracks items in flight and the table size, and checks the result channel.
// ----------------------------------------------------------------------------
module shbg_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_stall,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_stall,
    input wire logic [15:0]                 bucket,
    input wire logic                        last,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic                        pready,
    input wire logic [shbg_pkg::ADDR_W-1:0] paddr,
    input wire logic [31:0]                 pwdata
);

    logic [7:0]  pend_reg;
    logic [16:0] tbl_reg;
    logic        acc_in;
    logic        acc_last;

    assign acc_in   = req_valid && !req_stall;
    assign acc_last = rsp_valid && !rsp_stall && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'd0;
            tbl_reg  <= shbg_pkg::TABLE_SIZE_RST;
        end
        else
        begin
            pend_reg <= pend_reg + 8'(acc_in) - 8'(acc_last);
            if (psel && penable && pwrite && pready
                && shbg_pkg::reg_idx_t'(paddr[2]) == shbg_pkg::REG_TABLE_SIZE)
            begin
                tbl_reg <= pwdata[16:0];
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(bucket) && $stable(last))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 8'd0)
        else $error("result with no item in flight");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && tbl_reg != 17'd0 |-> {1'b0, bucket} < tbl_reg)
        else $error("bucket not below table size");

endmodule

bind spatial_hash_bucket_generator shbg_checker u_shbg_checker (.*);
`default_nettype wire

[dv/spatial_hash_bucket_generator_test.sv]
// ----------------------------------------------------------------------------
// spatial_hash_bucket_generator_test - bucket stream check of the hash block
// Positions are fed through a queued driver and every bucket that leaves is
// compared with a bucket list worked out in the bench itself. Cell and table
// sizes are rewritten between phases, extremes included, with random gaps on
// req and random back-pressure on rsp.
// ----------------------------------------------------------------------------
module spatial_hash_bucket_generator_test;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;
    localparam int BUCKET_LIMIT = 65536;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        shbg_pkg::op_t op;
        logic [31:0]   x;
        logic [31:0]   y;
        logic [31:0]   z;
    } pos_item_t;

    typedef struct {
        logic [15:0] bucket;
        logic        last;
    } bucket_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic                          opcode = 1'b0;
    logic signed [31:0]            pos_x = '0;
    logic signed [31:0]            pos_y = '0;
    logic signed [31:0]            pos_z = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic [15:0]                   bucket;
    logic                          last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [shbg_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // bench copy of the two registers
    logic [30:0]         cell_reg = shbg_pkg::CELL_SIZE_RST;
    logic [16:0]         table_reg = shbg_pkg::TABLE_SIZE_RST;

    pos_item_t           pending_items[$];
    bucket_result_t      expected_buckets[$];
    pos_item_t           bus_item;
    int                  idle_pct = 30;
    logic                hold_go = 1'b0;
    logic                hold_done = 1'b0;
    int                  hold_left = 0;
    int                  mismatches = 0;
    int                  cycles = 0;

    spatial_hash_bucket_generator
    #(
        .MAX_BUCKETS (BUCKET_LIMIT)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .bucket    (bucket),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    // append to the tail of the pending and expected queues
    task automatic queue_item(input pos_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic add_expected(input bucket_result_t r);
        expected_buckets = {expected_buckets, r};
    endtask

    // truncate toward zero: divide the magnitude, restore the sign
    function automatic logic [31:0] cell_index(input logic [31:0] coord,
                                               input logic [31:0] div);
        logic [31:0] mag;
        logic [31:0] q;
        mag = coord[31] ? (32'd0 - coord) : coord;
        q = mag / div;
        return coord[31] ? (32'd0 - q) : q;
    endfunction

    function automatic logic [15:0] cell_bucket(input logic [31:0] i,
                                                input logic [31:0] j,
                                                input logic [31:0] k);
        logic [31:0] h;
        logic [31:0] modulus;
        h = (i * HASH_PX) ^ (j * HASH_PY) ^ (k * HASH_PZ);
        if (table_reg == 17'd0)
        begin
            modulus = 32'd1;
        end
        else if (table_reg > 17'(BUCKET_LIMIT))
        begin
            modulus = BUCKET_LIMIT;
        end
        else
        begin
            modulus = {15'd0, table_reg};
        end
        return 16'(h % modulus);
    endfunction

    task automatic predict_buckets(input pos_item_t it);
        logic [31:0]    div;
        logic [31:0]    ix;
        logic [31:0]    iy;
        logic [31:0]    iz;
        bucket_result_t r;
        div = (cell_reg == 31'd0) ? 32'd1 : {1'b0, cell_reg};
        ix = cell_index(it.x, div);
        iy = cell_index(it.y, div);
        iz = cell_index(it.z, div);
        if (it.op == shbg_pkg::OP_INSERT)
        begin
            r.bucket = cell_bucket(ix, iy, iz);
            r.last = 1'b1;
            add_expected(r);
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        // neighbour indices wrap at 32 bits
                        r.bucket = cell_bucket(ix + 32'(a) - 32'd1,
                                               iy + 32'(b) - 32'd1,
                                               iz + 32'(c) - 32'd1);
                        r.last = (a == 2) && (b == 2) && (c == 2);
                        add_expected(r);
                    end
                end
            end
        end
    endtask

    function automatic pos_item_t make_item(input shbg_pkg::op_t op, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        pos_item_t it;
        it.op = op;
        it.x = x;
        it.y = y;
        it.z = z;
        return it;
    endfunction

    // values near cell boundaries, fully random ones, extremes and small signed ones
    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(5))
            0, 1:
            begin
                v = $urandom();
            end
            2:
            begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'd1;
                    default: v = 32'd0;
                endcase
            end
            3, 4:
            begin
                v = 32'({1'b0, cell_reg} * $urandom_range(8));
                v = v + 32'($urandom_range(2)) - 32'd1;
                if ($urandom_range(1) == 1)
                begin
                    v = 32'd0 - v;
                end
            end
            default:
            begin
                v = $urandom_range(32'h3_FFFF);
                if ($urandom_range(1) == 1)
                begin
                    v = 32'd0 - v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic pos_item_t random_item();
        shbg_pkg::op_t op;
        op = ($urandom_range(9) < 6) ? shbg_pkg::OP_QUERY : shbg_pkg::OP_INSERT;
        return make_item(op, random_coord(), random_coord(), random_coord());
    endfunction

    // setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access
    task automatic reg_write(input shbg_pkg::reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            shbg_pkg::REG_CELL_SIZE:  cell_reg = value[30:0];
            shbg_pkg::REG_TABLE_SIZE: table_reg = value[16:0];
        endcase
    endtask

    // hold until every item is in and every bucket is back, then let it settle
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || req_valid || expected_buckets.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: present the next pending item once the bus is free
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_buckets(bus_item);
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    bus_item = pending_items.pop_front();
                    opcode <= bus_item.op;
                    pos_x <= bus_item.x;
                    pos_y <= bus_item.y;
                    pos_z <= bus_item.z;
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted down once per cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && !hold_done)
            begin
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // monitor: compare each bucket, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        bucket_result_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_buckets.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected item: bucket %0d last %0b", bucket, last);
                    end
                end
                else
                begin
                    want = expected_buckets.pop_front();
                    if (bucket !== want.bucket || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: bucket exp %0d got %0d, last exp %0b got %0b",
                                     want.bucket, bucket, want.last, last);
                        end
                    end
                end
            end
            rsp_stall <= (hold_left > 0) || ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [30:0] cs;
        logic [16:0] ts;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: origin, extremes, fractions and negatives
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'd0, 32'd0, 32'd0));
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF));
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_0000,
                             32'h0000_FFFF));
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'hFFFE_FFFF, 32'h0001_8000,
                             32'hFFFE_8000));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'h0001_0000, 32'hFFFF_0001,
                             32'h5555_AAAA));
        drain();

        // zero cell size acts as one; oversized table saturates
        reg_write(shbg_pkg::REG_CELL_SIZE, 32'h8000_0000);
        reg_write(shbg_pkg::REG_TABLE_SIZE, 32'hFFFF_FFFF);
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF));
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000));
        drain();

        // widest cell, zero table: every bucket is zero
        reg_write(shbg_pkg::REG_CELL_SIZE, 32'h7FFF_FFFF);
        reg_write(shbg_pkg::REG_TABLE_SIZE, 32'd0);
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'h8000_0001));
        drain();

        // smallest real cell, table at the bucket limit
        reg_write(shbg_pkg::REG_CELL_SIZE, 32'd1);
        reg_write(shbg_pkg::REG_TABLE_SIZE, BUCKET_LIMIT);
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000));
        queue_item(make_item(shbg_pkg::OP_INSERT, 32'h1234_5678, 32'hEDCB_A987,
                             32'h0F0F_F0F0));
        drain();

        // odd cell, single bucket
        reg_write(shbg_pkg::REG_CELL_SIZE, 32'h0003_007B);
        reg_write(shbg_pkg::REG_TABLE_SIZE, 32'd1);
        queue_item(make_item(shbg_pkg::OP_QUERY, 32'h0003_007B, 32'hFFFC_FF85,
                             32'h0003_007A));
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case ($urandom_range(4))
                0: cs = 31'd0;
                1: cs = 31'($urandom_range(31'h0000_FFFF, 1));
                2: cs = 31'($urandom_range(31'h0003_0000, 31'h0000_4000));
                default: cs = 31'($urandom());
            endcase
            case ($urandom_range(5))
                0: ts = 17'd0;
                1: ts = 17'd1 << $urandom_range(16);
                2: ts = 17'($urandom_range(131071, 65537));
                3: ts = 17'($urandom_range(64, 1));
                default: ts = 17'($urandom_range(BUCKET_LIMIT, 1));
            endcase
            reg_write(shbg_pkg::REG_CELL_SIZE, {1'($urandom()), cs});
            reg_write(shbg_pkg::REG_TABLE_SIZE, {15'($urandom()), ts});
            idle_pct = (p == 2) ? 0 : 30;
            if (p == 4)
            begin
                hold_go <= 1'b1;
            end
            repeat (40) queue_item(random_item());
            // sender pauses here until the block has emptied
            drain();
            repeat (40) queue_item(random_item());
            drain();
        end

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
